/* rtl/lmtc_pkg.sv */
`timescale 1ns / 1ps

package lmtc_pkg;

  localparam int unsigned CountWidth = 11;
  localparam int unsigned LenWidth   = 10;
  localparam int unsigned LineWidth  = 8;
  localparam int unsigned StepWidth  = 5;
  localparam int unsigned IndexWidth = 3;

  localparam logic [LineWidth-1:0] VisibleLines = 8'd144;
  localparam logic [LineWidth-1:0] TotalLines   = 8'd154;

  localparam logic [LenWidth-1:0] OamCyclesRst    = 10'd80;
  localparam logic [LenWidth-1:0] VramCyclesRst   = 10'd172;
  localparam logic [LenWidth-1:0] HblankCyclesRst = 10'd204;
  localparam logic [LenWidth-1:0] VblankCyclesRst = 10'd456;

  typedef enum logic [1:0] {
    PHASE_HBLANK = 2'd0,
    PHASE_VBLANK = 2'd1,
    PHASE_OAM    = 2'd2,
    PHASE_VRAM   = 2'd3
  } mode_e;

  typedef enum logic [IndexWidth-1:0] {
    REG_OAM_CYCLES    = 3'd0,
    REG_VRAM_CYCLES   = 3'd1,
    REG_HBLANK_CYCLES = 3'd2,
    REG_VBLANK_CYCLES = 3'd3,
    REG_OAM_IRQ_EN    = 3'd4,
    REG_HBLANK_IRQ_EN = 3'd5,
    REG_VBLANK_IRQ_EN = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [LenWidth-1:0] oam_cycles;
    logic [LenWidth-1:0] vram_cycles;
    logic [LenWidth-1:0] hblank_cycles;
    logic [LenWidth-1:0] vblank_cycles;
    logic                oam_irq_en;
    logic                hblank_irq_en;
    logic                vblank_irq_en;
  } cfg_t;

  typedef struct packed {
    mode_e                video_mode;
    logic [LineWidth-1:0] line_number;
    logic                 draw_strobe;
    logic [LineWidth-1:0] drawn_line;
    logic                 stat_irq_request;
    logic                 vblank_irq_request;
  } res_t;

endpackage

/* rtl/lmtc_cfg.sv */
`timescale 1ns / 1ps

module lmtc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lmtc_pkg::IndexWidth-1:0]     cfg_index_i,
  input  logic [lmtc_pkg::LenWidth-1:0]       cfg_data_i,
  output lmtc_pkg::cfg_t                      cfg_o
);

  lmtc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (lmtc_pkg::cfg_idx_e'(cfg_index_i))
        lmtc_pkg::REG_OAM_CYCLES:    cfg_d.oam_cycles    = cfg_data_i;
        lmtc_pkg::REG_VRAM_CYCLES:   cfg_d.vram_cycles   = cfg_data_i;
        lmtc_pkg::REG_HBLANK_CYCLES: cfg_d.hblank_cycles = cfg_data_i;
        lmtc_pkg::REG_VBLANK_CYCLES: cfg_d.vblank_cycles = cfg_data_i;
        lmtc_pkg::REG_OAM_IRQ_EN:    cfg_d.oam_irq_en    = cfg_data_i[0];
        lmtc_pkg::REG_HBLANK_IRQ_EN: cfg_d.hblank_irq_en = cfg_data_i[0];
        lmtc_pkg::REG_VBLANK_IRQ_EN: cfg_d.vblank_irq_en = cfg_data_i[0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.oam_cycles    <= lmtc_pkg::OamCyclesRst;
      cfg_q.vram_cycles   <= lmtc_pkg::VramCyclesRst;
      cfg_q.hblank_cycles <= lmtc_pkg::HblankCyclesRst;
      cfg_q.vblank_cycles <= lmtc_pkg::VblankCyclesRst;
      cfg_q.oam_irq_en    <= 1'b0;
      cfg_q.hblank_irq_en <= 1'b0;
      cfg_q.vblank_irq_en <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/lmtc_core.sv */
`timescale 1ns / 1ps

module lmtc_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic [lmtc_pkg::StepWidth-1:0]   cycles_i,
  input  lmtc_pkg::cfg_t                   cfg_i,
  output lmtc_pkg::res_t                   res_o
);

  logic [lmtc_pkg::CountWidth-1:0] count_q, count_d;
  lmtc_pkg::mode_e                 mode_q, mode_d;
  logic [lmtc_pkg::LineWidth-1:0]  line_q, line_d;

  logic [lmtc_pkg::CountWidth-1:0] sum;
  logic [lmtc_pkg::CountWidth-1:0] len;
  logic                            done;
  logic [lmtc_pkg::LineWidth-1:0]  line_inc;

  always_comb begin
    sum = count_q + {{(lmtc_pkg::CountWidth-lmtc_pkg::StepWidth){1'b0}}, cycles_i};
    case (mode_q)
      lmtc_pkg::PHASE_OAM:    len = {1'b0, cfg_i.oam_cycles};
      lmtc_pkg::PHASE_VRAM:   len = {1'b0, cfg_i.vram_cycles};
      lmtc_pkg::PHASE_HBLANK: len = {1'b0, cfg_i.hblank_cycles};
      default:                len = {1'b0, cfg_i.vblank_cycles};
    endcase
    done     = (sum >= len);
    line_inc = line_q + 8'd1;

    count_d = done ? (sum - len) : sum;
    mode_d  = mode_q;
    line_d  = line_q;
    res_o.draw_strobe        = 1'b0;
    res_o.drawn_line         = '0;
    res_o.stat_irq_request   = 1'b0;
    res_o.vblank_irq_request = 1'b0;

    if (done) begin
      case (mode_q)
        lmtc_pkg::PHASE_OAM: begin
          mode_d                 = lmtc_pkg::PHASE_VRAM;
          res_o.stat_irq_request = cfg_i.oam_irq_en;
        end
        lmtc_pkg::PHASE_VRAM: begin
          mode_d = lmtc_pkg::PHASE_HBLANK;
        end
        lmtc_pkg::PHASE_HBLANK: begin
          line_d                 = line_inc;
          mode_d                 = (line_inc >= lmtc_pkg::VisibleLines) ?
                                   lmtc_pkg::PHASE_VBLANK : lmtc_pkg::PHASE_OAM;
          res_o.draw_strobe      = 1'b1;
          res_o.drawn_line       = line_q;
          res_o.stat_irq_request = cfg_i.hblank_irq_en;
        end
        default: begin
          // vblank line end; wrap to line 0 after the last one
          if (line_inc >= lmtc_pkg::TotalLines) begin
            line_d = '0;
            mode_d = lmtc_pkg::PHASE_OAM;
          end else begin
            line_d = line_inc;
          end
          res_o.vblank_irq_request = cfg_i.vblank_irq_en;
        end
      endcase
    end

    res_o.video_mode  = mode_d;
    res_o.line_number = line_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mode_q  <= lmtc_pkg::PHASE_OAM;
      line_q  <= '0;
    end else if (step_i) begin
      count_q <= count_d;
      mode_q  <= mode_d;
      line_q  <= line_d;
    end
  end

  a_strobe_then_oam_or_vblank: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.draw_strobe |=>
      (mode_q == lmtc_pkg::PHASE_OAM || mode_q == lmtc_pkg::PHASE_VBLANK))
    else $error("hblank end did not move to OAM or vblank");

  a_vblank_req_in_vblank: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.vblank_irq_request |-> mode_q == lmtc_pkg::PHASE_VBLANK)
    else $error("vblank request outside vertical blank");

  a_state_held_when_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(count_q) && $stable(line_q) && $stable(mode_q))
    else $error("timing state moved without a word");

endmodule

/* rtl/lcd_mode_timing_controller_top.sv */
`timescale 1ns / 1ps

// Channel  Dir  Handshake                  Payload
// -------  ---  -------------------------  ------------------------------------
// in       in   in_valid_i / in_stall_o    cycles_elapsed_i
// out      out  out_valid_o / out_stall_i  video_mode_o, line_number_o,
//                                          draw_strobe_o, drawn_line_o,
//                                          stat_irq_request_o, vblank_irq_request_o
// cfg      in   cfg_we_i                   cfg_index_i, cfg_data_i
//
// One word per cycle while the output is not stalled; a word that is taken goes
// into the input register, then through the step logic into the result register.
// The rate is set by the single add / compare / subtract on the cycle counter.
// Reset puts the timing in OAM access on line 0 with a zero counter and the
// default mode lengths; no clearing pass.
// A stall on the output backs up into the input register; in_stall_o rises
// only when both registers hold a word.

module lcd_mode_timing_controller_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lmtc_pkg::StepWidth-1:0]      cycles_elapsed_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          video_mode_o,
  output logic [lmtc_pkg::LineWidth-1:0]      line_number_o,
  output logic                                draw_strobe_o,
  output logic [lmtc_pkg::LineWidth-1:0]      drawn_line_o,
  output logic                                stat_irq_request_o,
  output logic                                vblank_irq_request_o,
  input  logic                                cfg_we_i,
  input  logic [lmtc_pkg::IndexWidth-1:0]     cfg_index_i,
  input  logic [lmtc_pkg::LenWidth-1:0]       cfg_data_i
);

  lmtc_pkg::cfg_t cfg;
  lmtc_pkg::res_t res;

  // input register
  logic                           s1_valid_q, s1_valid_d;
  logic [lmtc_pkg::StepWidth-1:0] s1_cycles_q;
  // result register
  logic                           out_valid_q, out_valid_d;
  lmtc_pkg::res_t                 out_q;

  logic in_fire;
  logic out_free;
  logic step;

  // result slot can take a word if empty or being drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_free ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cycles_q <= cycles_elapsed_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  lmtc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // mode / line state advances exactly when a word moves into the result register
  lmtc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cycles_i (s1_cycles_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  assign out_valid_o          = out_valid_q;
  assign video_mode_o         = out_q.video_mode;
  assign line_number_o        = out_q.line_number;
  assign draw_strobe_o        = out_q.draw_strobe;
  assign drawn_line_o         = out_q.drawn_line;
  assign stat_irq_request_o   = out_q.stat_irq_request;
  assign vblank_irq_request_o = out_q.vblank_irq_request;

  a_accept_fills_input_reg: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted word missing from input register");

  a_backpressure_keeps_word: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q && out_valid_q)
    else $error("word dropped while output stalled");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for the LCD mode timing controller.
// Each step word reports elapsed CPU time. The scoreboard keeps its own copy of the
// step accumulator, mode and line, and the register set. From every accepted word it
// predicts one result word, and each result word that leaves the block is checked
// against that prediction, field by field.

module tb_top;

  localparam int unsigned CountWidth = lmtc_pkg::CountWidth;
  localparam int unsigned LenWidth   = lmtc_pkg::LenWidth;
  localparam int unsigned LineWidth  = lmtc_pkg::LineWidth;
  localparam int unsigned StepWidth  = lmtc_pkg::StepWidth;
  localparam int unsigned IndexWidth = lmtc_pkg::IndexWidth;

  // Register index 7 maps to no register, so the block ignores writes to it.
  localparam logic [IndexWidth-1:0] RegUnused = 3'd7;
  localparam int unsigned StepWords  = 1800;
  localparam int unsigned LimitCycles = 600000;
  // The hold-off point falls in the stretch where neither side idles.
  localparam int unsigned HoldAtWord  = 1400;
  localparam int unsigned HoldCycles  = 80;

  class lcd_timing_scoreboard;
    // register copy
    logic [LenWidth-1:0] oam_len, vram_len, hblank_len, vblank_len;
    logic oam_irq_en, hblank_irq_en, vblank_irq_en;
    // timing state copy
    logic [CountWidth-1:0] cycle_acc;
    lmtc_pkg::mode_e       mode;
    logic [LineWidth-1:0]  line;
    lmtc_pkg::res_t timing_results_q[$];
    int unsigned errors;

    function new();
      oam_len       = lmtc_pkg::OamCyclesRst;
      vram_len      = lmtc_pkg::VramCyclesRst;
      hblank_len    = lmtc_pkg::HblankCyclesRst;
      vblank_len    = lmtc_pkg::VblankCyclesRst;
      oam_irq_en    = 1'b0;
      hblank_irq_en = 1'b0;
      vblank_irq_en = 1'b0;
      cycle_acc     = '0;
      mode          = lmtc_pkg::PHASE_OAM;
      line          = '0;
      errors        = 0;
    endfunction

    function void write_reg(logic [IndexWidth-1:0] idx, logic [LenWidth-1:0] data);
      case (idx)
        lmtc_pkg::REG_OAM_CYCLES:    oam_len       = data;
        lmtc_pkg::REG_VRAM_CYCLES:   vram_len      = data;
        lmtc_pkg::REG_HBLANK_CYCLES: hblank_len    = data;
        lmtc_pkg::REG_VBLANK_CYCLES: vblank_len    = data;
        lmtc_pkg::REG_OAM_IRQ_EN:    oam_irq_en    = data[0];
        lmtc_pkg::REG_HBLANK_IRQ_EN: hblank_irq_en = data[0];
        lmtc_pkg::REG_VBLANK_IRQ_EN: vblank_irq_en = data[0];
        default: ;
      endcase
    endfunction

    // Advance the scan timing by one step word and queue the result it causes.
    function void note_step(logic [StepWidth-1:0] cyc);
      lmtc_pkg::res_t r;
      r = '0;
      cycle_acc = cycle_acc + CountWidth'(cyc);
      case (mode)
        lmtc_pkg::PHASE_OAM: begin
          if (cycle_acc >= CountWidth'(oam_len)) begin
            cycle_acc = cycle_acc - CountWidth'(oam_len);
            mode = lmtc_pkg::PHASE_VRAM;
            r.stat_irq_request = oam_irq_en;
          end
        end
        lmtc_pkg::PHASE_VRAM: begin
          if (cycle_acc >= CountWidth'(vram_len)) begin
            cycle_acc = cycle_acc - CountWidth'(vram_len);
            mode = lmtc_pkg::PHASE_HBLANK;
          end
        end
        lmtc_pkg::PHASE_HBLANK: begin
          if (cycle_acc >= CountWidth'(hblank_len)) begin
            cycle_acc = cycle_acc - CountWidth'(hblank_len);
            r.draw_strobe = 1'b1;
            r.drawn_line  = line;
            line = line + 1'b1;
            mode = (line >= lmtc_pkg::VisibleLines) ? lmtc_pkg::PHASE_VBLANK
                                                    : lmtc_pkg::PHASE_OAM;
            r.stat_irq_request = hblank_irq_en;
          end
        end
        default: begin
          if (cycle_acc >= CountWidth'(vblank_len)) begin
            cycle_acc = cycle_acc - CountWidth'(vblank_len);
            line = line + 1'b1;
            if (line >= lmtc_pkg::TotalLines) begin
              line = '0;
              mode = lmtc_pkg::PHASE_OAM;
            end
            r.vblank_irq_request = vblank_irq_en;
          end
        end
      endcase
      r.video_mode  = mode;
      r.line_number = line;
      timing_results_q.push_back(r);
    endfunction

    function void check_timing_result(lmtc_pkg::res_t got);
      lmtc_pkg::res_t want;
      if (timing_results_q.size() == 0) begin
        $error("result word with none expected: video_mode %0d line_number %0d",
               got.video_mode, got.line_number);
        errors++;
        return;
      end
      want = timing_results_q.pop_front();
      if (got.video_mode !== want.video_mode) begin
        $error("video_mode: expected %0d, actual %0d", want.video_mode, got.video_mode);
        errors++;
      end
      if (got.line_number !== want.line_number) begin
        $error("line_number: expected %0d, actual %0d", want.line_number, got.line_number);
        errors++;
      end
      if (got.draw_strobe !== want.draw_strobe) begin
        $error("draw_strobe: expected %0d, actual %0d", want.draw_strobe, got.draw_strobe);
        errors++;
      end
      if (got.drawn_line !== want.drawn_line) begin
        $error("drawn_line: expected %0d, actual %0d", want.drawn_line, got.drawn_line);
        errors++;
      end
      if (got.stat_irq_request !== want.stat_irq_request) begin
        $error("stat_irq_request: expected %0d, actual %0d",
               want.stat_irq_request, got.stat_irq_request);
        errors++;
      end
      if (got.vblank_irq_request !== want.vblank_irq_request) begin
        $error("vblank_irq_request: expected %0d, actual %0d",
               want.vblank_irq_request, got.vblank_irq_request);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return timing_results_q.size();
    endfunction
  endclass

  // Every input of the block starts from a known value.
  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  in_valid_i       = 1'b0;
  logic [StepWidth-1:0]  cycles_elapsed_i = '0;
  logic                  out_stall_i      = 1'b0;
  logic                  cfg_we_i         = 1'b0;
  logic [IndexWidth-1:0] cfg_index_i      = '0;
  logic [LenWidth-1:0]   cfg_data_i       = '0;

  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [1:0]            video_mode_o;
  logic [LineWidth-1:0]  line_number_o;
  logic                  draw_strobe_o;
  logic [LineWidth-1:0]  drawn_line_o;
  logic                  stat_irq_request_o;
  logic                  vblank_irq_request_o;

  lcd_timing_scoreboard sb = new();

  int unsigned words_sent      = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned hold_left       = 0;
  bit          hold_done       = 1'b0;
  int unsigned cycle_cnt       = 0;

  lcd_mode_timing_controller_top dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .cycles_elapsed_i     (cycles_elapsed_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .video_mode_o         (video_mode_o),
    .line_number_o        (line_number_o),
    .draw_strobe_o        (draw_strobe_o),
    .drawn_line_o         (drawn_line_o),
    .stat_irq_request_o   (stat_irq_request_o),
    .vblank_irq_request_o (vblank_irq_request_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  // 4 ns clock.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Watchdog: a hung handshake or a lost word ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LimitCycles) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver side. It stalls at random, except for one long hold-off, counted here.
  // The hold-off starts late in the run while the sender is offering words, so both
  // internal registers fill and in_stall_o has to rise.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (!hold_done && words_sent >= HoldAtWord && in_valid_i) begin
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result monitor. It samples at the edge, so it sees the values that held before it.
  always @(posedge clk_i) begin
    lmtc_pkg::res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.video_mode         = lmtc_pkg::mode_e'(video_mode_o);
      got.line_number        = line_number_o;
      got.draw_strobe        = draw_strobe_o;
      got.drawn_line         = drawn_line_o;
      got.stat_irq_request   = stat_irq_request_o;
      got.vblank_irq_request = vblank_irq_request_o;
      sb.check_timing_result(got);
    end
  end

  // One register write. The caller lowers the write enable after the last write.
  task automatic cfg_word(input logic [IndexWidth-1:0] idx, input logic [LenWidth-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Full register set, plus a stray write to the unused index, which has to change
  // nothing. The enables take full 10-bit data, so only bit 0 may count.
  task automatic program_timing(input logic [LenWidth-1:0] oam, vram, hblank, vblank,
                                input logic [LenWidth-1:0] oam_en, hb_en, vb_en);
    cfg_word(lmtc_pkg::REG_OAM_CYCLES, oam);
    cfg_word(lmtc_pkg::REG_VRAM_CYCLES, vram);
    cfg_word(lmtc_pkg::REG_HBLANK_CYCLES, hblank);
    cfg_word(lmtc_pkg::REG_VBLANK_CYCLES, vblank);
    cfg_word(lmtc_pkg::REG_OAM_IRQ_EN, oam_en);
    cfg_word(lmtc_pkg::REG_HBLANK_IRQ_EN, hb_en);
    cfg_word(lmtc_pkg::REG_VBLANK_IRQ_EN, vb_en);
    cfg_word(RegUnused, LenWidth'($urandom_range(1023)));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one step word. It may idle first, then holds the word until it is taken.
  task automatic send_step(input logic [StepWidth-1:0] cyc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    cycles_elapsed_i <= cyc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_step(cyc);
    words_sent++;
  endtask

  // Idle rates follow the progress of the run: receiver-heavy idling, then
  // sender-heavy idling, then a stretch with none.
  task automatic update_idling();
    if (words_sent < StepWords / 3) begin
      send_idle_pct = 38;
      recv_idle_pct = 78;
    end else if (words_sent < 2 * StepWords / 3) begin
      send_idle_pct = 78;
      recv_idle_pct = 38;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // Config writes happen only once every expected word has come back.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random_steps(input int unsigned n_words);
    logic [StepWidth-1:0] cyc;
    for (int unsigned k = 0; k < n_words; k++) begin
      update_idling();
      // Mostly uniform, with extra weight on 0 and 31.
      case ($urandom_range(9))
        0:       cyc = '0;
        1:       cyc = '1;
        default: cyc = StepWidth'($urandom_range(31));
      endcase
      send_step(cyc);
    end
    wait_drain();
  endtask

  // Mode length for one random phase. Tiny lengths, below the largest step word, end a
  // mode on almost every word, so full frames with vblank and line wrap fit in the run.
  function automatic logic [LenWidth-1:0] pick_len(input int unsigned kind);
    case (kind)
      0, 1, 2, 3, 4, 5: return LenWidth'($urandom_range(8));
      6, 7:             return LenWidth'($urandom_range(64, 9));
      8: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return LenWidth'(1);
          2:       return LenWidth'(31);
          default: return LenWidth'(32);
        endcase
      end
      default:          return ($urandom_range(1)) ? '1 : LenWidth'($urandom_range(1023, 512));
    endcase
  endfunction

  // Directed steps from reset with the default lengths: the field extremes, single
  // bits, and enough cycles to end OAM and VRAM with interrupts off.
  localparam int unsigned DirectedSteps = 14;
  logic [StepWidth-1:0] directed_steps [DirectedSteps] = '{
    5'd0, 5'd31, 5'd31, 5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16,
    5'd31, 5'd31, 5'd31, 5'd31, 5'd31
  };

  initial begin
    int unsigned kind;
    int unsigned n_words;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    update_idling();
    foreach (directed_steps[i]) send_step(directed_steps[i]);
    wait_drain();

    // Zero-length modes: every word ends a mode and nothing is taken off the counter. All
    // interrupts are enabled with all-ones data.
    program_timing('0, '0, '0, '0, '1, '1, '1);
    for (int unsigned k = 0; k < 10; k++) begin
      update_idling();
      send_step(StepWidth'($urandom_range(31)));
    end
    wait_drain();

    // Large lengths, so the counter is left well above the lengths that follow. The
    // next phase then covers lengths lowered in the middle of a mode.
    program_timing('1, '1, '1, '1, 10'h3FE, 10'h3FE, 10'h3FE);
    run_random_steps(40);

    // A long run with tiny lengths, enough to cross into vblank and wrap to line 0.
    program_timing(10'd2, 10'd1, 10'd3, 10'd1, 10'd1, 10'd0, 10'd1);
    run_random_steps(500);

    // Random settings from here on.
    while (words_sent < StepWords) begin
      kind = $urandom_range(9);
      program_timing(pick_len(kind), pick_len(kind), pick_len(kind), pick_len(kind),
                     LenWidth'($urandom_range(1023)), LenWidth'($urandom_range(1023)),
                     LenWidth'($urandom_range(1023)));
      n_words = $urandom_range(200, 80);
      if (words_sent + n_words > StepWords) n_words = StepWords - words_sent;
      run_random_steps(n_words);
    end

    // Leave time for any word that should not come.
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
